/* hdl/bsmt_pkg.sv */
// ----------------------------------------------------------------------------
// bsmt_pkg - backing-store map table shared definitions
// Sizes, command codes, slot record type and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsmt_pkg;

  localparam int SLOTS      = 8;
  localparam int PAGE_SHIFT = 12;

  localparam int SLOT_W   = (SLOTS > 2) ? $clog2(SLOTS) : 1;
  localparam int CMD_W    = 3;
  localparam int PID_W    = 6;
  localparam int OWNER_W  = 7;
  localparam int VADDR_W  = 32;
  localparam int PAGE_W   = 20;
  localparam int IDX_W    = 3;
  localparam int PCNT_W   = 9;
  localparam int MCNT_W   = 6;
  localparam int OFF_W    = 21;
  localparam int VPN_W    = VADDR_W - PAGE_SHIFT;
  localparam int DIFF_W   = ((VPN_W > PAGE_W) ? VPN_W : PAGE_W) + 2;
  localparam int OFF_MAX  = 1048575;

  localparam logic [OWNER_W-1:0] OWNER_NONE = {OWNER_W{1'b1}};
  localparam logic [PAGE_W-1:0]  BASE_RESET = PAGE_W'(4096);
  localparam logic [MCNT_W-1:0]  COUNT_MAX  = {MCNT_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_ALLOC  = 3'd1,
    CMD_FREE   = 3'd2,
    CMD_LOOKUP = 3'd3,
    CMD_MAP    = 3'd4,
    CMD_UNMAP  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic                mapped;
    logic [OWNER_W-1:0]  owner;
    logic [PAGE_W-1:0]   base;
    logic [PCNT_W-1:0]   pages;
    logic [MCNT_W-1:0]   count;
  } slot_t;

  localparam slot_t SLOT_RESET = '{
    mapped: 1'b0,
    owner:  OWNER_NONE,
    base:   BASE_RESET,
    pages:  '0,
    count:  '0
  };

  typedef struct packed {
    logic                     free_hit;
    logic                     pid_hit;
    logic signed [OFF_W-1:0]  offset;
    slot_t                    upd;
  } unit_res_t;

endpackage

`default_nettype wire

/* hdl/bsmt_slot_file.sv */
// ----------------------------------------------------------------------------
// bsmt_slot_file - slot record storage
// One write port, one read port; all records return to reset values on reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsmt_slot_file (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            we_i,
  input  wire  [bsmt_pkg::SLOT_W-1:0]    idx_i,
  input  bsmt_pkg::slot_t                wdata_i,
  output bsmt_pkg::slot_t                rdata_o
);

  bsmt_pkg::slot_t slot_q [bsmt_pkg::SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bsmt_pkg::SLOTS; i++) begin
        slot_q[i] <= bsmt_pkg::SLOT_RESET;
      end
    end else if (we_i) begin
      slot_q[idx_i] <= wdata_i;
    end
  end

  assign rdata_o = slot_q[idx_i];

endmodule

`default_nettype wire

/* hdl/bsmt_unit.sv */
// ----------------------------------------------------------------------------
// bsmt_unit - shared slot evaluation unit
// Compares one slot against the command, forms the page offset and the
// updated slot record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsmt_unit (
  input  bsmt_pkg::cmd_e                  cmd_i,
  input  wire  [bsmt_pkg::PID_W-1:0]      pid_i,
  input  wire  [bsmt_pkg::VADDR_W-1:0]    vaddr_i,
  input  wire  [bsmt_pkg::PAGE_W-1:0]     base_page_i,
  input  wire  [bsmt_pkg::PCNT_W-1:0]     page_count_i,
  input  bsmt_pkg::slot_t                 entry_i,
  output bsmt_pkg::unit_res_t             res_o
);

  logic [bsmt_pkg::VPN_W-1:0]          vpn;
  logic signed [bsmt_pkg::DIFF_W-1:0]  diff;
  logic [bsmt_pkg::MCNT_W-1:0]         cnt_dn;
  bsmt_pkg::slot_t                     upd;

  assign vpn  = vaddr_i[bsmt_pkg::VADDR_W-1:bsmt_pkg::PAGE_SHIFT];
  assign diff = $signed(bsmt_pkg::DIFF_W'(vpn)) - $signed(bsmt_pkg::DIFF_W'(entry_i.base));
  assign cnt_dn = (entry_i.count != '0) ? entry_i.count - 1'b1 : '0;

  always_comb begin
    upd = entry_i;
    unique case (cmd_i)
      bsmt_pkg::CMD_CLEAR: begin
        upd = bsmt_pkg::SLOT_RESET;
      end
      bsmt_pkg::CMD_FREE: begin
        upd.mapped = 1'b0;
      end
      bsmt_pkg::CMD_MAP: begin
        if (!entry_i.mapped) begin
          upd.mapped = 1'b1;
          upd.pages  = page_count_i;
        end
        upd.owner = {1'b0, pid_i};
        upd.base  = base_page_i;
        if (entry_i.count != bsmt_pkg::COUNT_MAX) begin
          upd.count = entry_i.count + 1'b1;
        end
      end
      bsmt_pkg::CMD_UNMAP: begin
        if (cnt_dn == '0) begin
          upd = bsmt_pkg::SLOT_RESET;
        end else begin
          upd.count = cnt_dn;
        end
      end
      default: begin
        upd = entry_i;
      end
    endcase
  end

  always_comb begin
    res_o.free_hit = !entry_i.mapped;
    res_o.pid_hit  = (entry_i.owner == {1'b0, pid_i});
    res_o.upd      = upd;
    priority if (diff > $signed(bsmt_pkg::DIFF_W'(bsmt_pkg::OFF_MAX))) begin
      res_o.offset = bsmt_pkg::OFF_W'(bsmt_pkg::OFF_MAX);
    end else if (diff < -$signed(bsmt_pkg::DIFF_W'(bsmt_pkg::OFF_MAX))) begin
      res_o.offset = -$signed(bsmt_pkg::OFF_W'(bsmt_pkg::OFF_MAX));
    end else begin
      res_o.offset = diff[bsmt_pkg::OFF_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* hdl/backing_store_map_table.sv */
// ----------------------------------------------------------------------------
// backing_store_map_table - backing-store slot table
// Clear, allocate, free, lookup, map and unmap over a small slot table,
// one slot evaluated per cycle by a shared unit while no held result stalls it.
// ----------------------------------------------------------------------------
//  channel   dir  tdata / tuser
//  s_axis    in   tuser: cmd; tdata: pid, vaddr, base_page, slot, page_count
//  m_axis    out  tdata: status, found_slot, page_offset
//
//  A new word is taken only in idle. Clear all walks every slot, allocate and
//  lookup scan from slot 0 and stop at the first hit, others touch one slot.
//  The scan walks the slot file through one read port and the shared unit.
//  Reset returns every slot to its reset values at once.
//  A held result stalls the last run cycle; no input is taken while it waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module backing_store_map_table (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [71:0] s_axis_tdata_i,   // pid[5:0] vaddr[37:6] base_page[57:38]
                                        // slot[60:58] page_count[69:61]
  input  wire  [2:0]  s_axis_tuser_i,   // cmd[2:0]
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // status[0] found_slot[3:1] page_offset[24:4]
);

  bsmt_pkg::state_e                   state_q, state_d;
  bsmt_pkg::cmd_e                     cmd_q;
  logic [bsmt_pkg::PID_W-1:0]         pid_q;
  logic [bsmt_pkg::VADDR_W-1:0]       vaddr_q;
  logic [bsmt_pkg::PAGE_W-1:0]        base_q;
  logic [bsmt_pkg::IDX_W-1:0]         slot_q;
  logic [bsmt_pkg::PCNT_W-1:0]        pcnt_q;
  logic [bsmt_pkg::SLOT_W-1:0]        idx_q, idx_d;
  logic                               out_valid_q;
  logic                               status_q;
  logic [bsmt_pkg::IDX_W-1:0]         found_q;
  logic signed [bsmt_pkg::OFF_W-1:0]  off_q;

  bsmt_pkg::cmd_e                     in_cmd;
  bsmt_pkg::slot_t                    entry;
  bsmt_pkg::unit_res_t                ures;
  logic                               accept;
  logic                               last;
  logic                               slot_ok;
  logic                               done;
  logic                               stall;
  logic                               we;
  logic                               res_status;
  logic [bsmt_pkg::IDX_W-1:0]         res_found;
  logic signed [bsmt_pkg::OFF_W-1:0]  res_off;

  assign in_cmd  = bsmt_pkg::cmd_e'(s_axis_tuser_i);
  assign s_axis_tready_o = (state_q == bsmt_pkg::ST_IDLE);
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign last    = (idx_q == bsmt_pkg::SLOT_W'(bsmt_pkg::SLOTS - 1));
  assign slot_ok = (32'(slot_q) < bsmt_pkg::SLOTS);
  assign stall   = done && out_valid_q && !m_axis_tready_i;

  bsmt_slot_file u_file (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .idx_i   (idx_q),
    .wdata_i (ures.upd),
    .rdata_o (entry)
  );

  bsmt_unit u_unit (
    .cmd_i        (cmd_q),
    .pid_i        (pid_q),
    .vaddr_i      (vaddr_q),
    .base_page_i  (base_q),
    .page_count_i (pcnt_q),
    .entry_i      (entry),
    .res_o        (ures)
  );

  always_comb begin
    done       = 1'b0;
    we         = 1'b0;
    res_status = 1'b0;
    res_found  = '0;
    res_off    = '0;
    state_d    = state_q;
    idx_d      = idx_q;
    unique case (state_q)
      bsmt_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = bsmt_pkg::ST_RUN;
          if (in_cmd == bsmt_pkg::CMD_FREE || in_cmd == bsmt_pkg::CMD_MAP ||
              in_cmd == bsmt_pkg::CMD_UNMAP) begin
            idx_d = bsmt_pkg::SLOT_W'(s_axis_tdata_i[60:58]);
          end else begin
            idx_d = '0;
          end
        end
      end
      bsmt_pkg::ST_RUN: begin
        unique case (cmd_q)
          bsmt_pkg::CMD_CLEAR: begin
            done = last;
            we   = 1'b1;
          end
          bsmt_pkg::CMD_ALLOC: begin
            done       = ures.free_hit || last;
            res_status = !ures.free_hit;
            res_found  = ures.free_hit ? bsmt_pkg::IDX_W'(idx_q) : '0;
          end
          bsmt_pkg::CMD_LOOKUP: begin
            done       = ures.pid_hit || last;
            res_status = !ures.pid_hit;
            res_found  = ures.pid_hit ? bsmt_pkg::IDX_W'(idx_q) : '0;
            res_off    = ures.pid_hit ? ures.offset : '0;
          end
          bsmt_pkg::CMD_FREE, bsmt_pkg::CMD_MAP, bsmt_pkg::CMD_UNMAP: begin
            done = 1'b1;
            we   = slot_ok;
          end
          default: begin
            done       = 1'b1;
            res_status = 1'b1;
          end
        endcase
        if (stall) begin
          we = 1'b0;
        end else if (done) begin
          state_d = bsmt_pkg::ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: begin
        state_d = bsmt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsmt_pkg::ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (done && !stall && state_q == bsmt_pkg::ST_RUN) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= in_cmd;
      pid_q   <= s_axis_tdata_i[5:0];
      vaddr_q <= s_axis_tdata_i[37:6];
      base_q  <= s_axis_tdata_i[57:38];
      slot_q  <= s_axis_tdata_i[60:58];
      pcnt_q  <= s_axis_tdata_i[69:61];
    end
    if (done && !stall && state_q == bsmt_pkg::ST_RUN) begin
      status_q <= res_status;
      found_q  <= res_found;
      off_q    <= res_off;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, off_q, found_q, status_q};

endmodule

`default_nettype wire

/* hdl/bsmt_checker.sv */
// ----------------------------------------------------------------------------
// bsmt_checker - port-level checks for the slot table
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsmt_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid_i,
  input wire        s_axis_tready_o,
  input wire        m_axis_tvalid_o,
  input wire        m_axis_tready_i,
  input wire [31:0] m_axis_tdata_o
);

  // busy after taking a word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input ready right after accept");

  // a new result only comes out of a run cycle
  a_result_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("result without a run cycle");

  // error words carry no slot and no offset
  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |-> m_axis_tdata_o[24:1] == 24'd0)
    else $error("error word with slot or offset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled output word changed");

endmodule

bind backing_store_map_table bsmt_checker u_bsmt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
